FILE: design/sch_pkg.sv
// Shared types, constants and fixed-point helpers for the swept circle hit test.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sch_pkg;

  localparam int MAX_STEPS  = 64;
  localparam int ANGLE_BITS = 12;

  localparam int POS_W   = 16;
  localparam int LEN_W   = 12;
  localparam int RAD_W   = LEN_W + 1;
  localparam int TRIG_W  = 16;
  localparam int MULA_W  = 17;
  localparam int MULB_W  = 14;
  localparam int PROD_W  = MULA_W + MULB_W;
  localparam int RND_W   = PROD_W - 14;
  localparam int PATH_W  = 20;
  localparam int DIFF_W  = PATH_W + 1;
  localparam int SQ_W    = 2 * DIFF_W - 1;
  localparam int RR_W    = 2 * RAD_W;
  localparam int ACC_W   = RAD_W + 1;
  localparam int CNT_W   = $clog2(MAX_STEPS + 1);
  localparam int CLIP_W  = RAD_W + CNT_W;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [14:0] QSINE [17] = '{
    15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
    15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
    15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
  };

  typedef enum logic [1:0] {
    F_IDLE,
    F_TRIG,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_LAST,
    B_DRAIN
  } back_state_e;

  typedef enum logic [2:0] {
    MUL_CSPD,
    MUL_SSPD,
    MUL_CR,
    MUL_SR,
    MUL_RR
  } mul_op_e;

  typedef struct packed {
    logic signed [POS_W-1:0]  mx;
    logic signed [POS_W-1:0]  my;
    logic signed [POS_W-1:0]  tx;
    logic signed [POS_W-1:0]  ty;
    logic signed [PATH_W-1:0] px0;
    logic signed [PATH_W-1:0] py0;
    logic signed [PATH_W-1:0] stx;
    logic signed [PATH_W-1:0] sty;
    logic [RAD_W-1:0]         r;
    logic [LEN_W-1:0]         spd;
    logic [RR_W-1:0]          r2;
    logic                     do_path;
    logic                     clipped;
  } job_t;

  // Sine over one quarter turn, p in 0..0x4000, Q1.14.
  function automatic logic [14:0] quarter_lookup(input logic [14:0] p);
    logic [4:0]  idx;
    logic [9:0]  frac;
    logic [14:0] base;
    logic [14:0] diff;
    logic [24:0] term;
    idx  = p[14:10];
    frac = p[9:0];
    if (idx >= 5'd16) begin
      return 15'd16384;
    end
    base = QSINE[idx];
    diff = QSINE[idx + 5'd1] - base;
    term = 25'(diff) * 25'(frac) + 25'd512;
    return base + 15'(term >> 10);
  endfunction

  // Sine of a 16-bit binary angle, signed Q1.14.
  function automatic logic signed [TRIG_W-1:0] sine16(input logic [15:0] a);
    logic [1:0]  quad;
    logic [13:0] qpos;
    logic [14:0] v;
    quad = a[15:14];
    qpos = a[13:0];
    if (quad[0]) begin
      v = quarter_lookup(15'h4000 - {1'b0, qpos});
    end else begin
      v = quarter_lookup({1'b0, qpos});
    end
    return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  // Round a Q.14 product to Q.0, half up.
  function automatic logic signed [RND_W-1:0] round14(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W:0] t;
    t = $signed((PROD_W+1)'(v)) + $signed((PROD_W+1)'(8192));
    return RND_W'(t >>> 14);
  endfunction

endpackage

FILE: design/sch_fifo.sv
// Two-entry job queue between the setup front end and the sampling back end.
// Depends on sch_pkg for the job record type.
`timescale 1ns / 1ps

module sch_fifo
  import sch_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

FILE: design/sch_front.sv
// Setup front end: takes a transaction, finds heading sine and cosine, and
// works out start point, step vector and r squared on one shared multiplier.
// Depends on sch_pkg.
`timescale 1ns / 1ps

module sch_front
  import sch_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] mover_x_i,
  input  logic signed [POS_W-1:0] mover_y_i,
  input  logic signed [POS_W-1:0] target_x_i,
  input  logic signed [POS_W-1:0] target_y_i,
  input  logic [LEN_W-1:0]        mover_radius_i,
  input  logic [LEN_W-1:0]        target_radius_i,
  input  logic [LEN_W-1:0]        mover_speed_i,
  input  logic [LEN_W-1:0]        heading_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output job_t                    q_job_o
);

  front_state_e             state_q, state_d;
  mul_op_e                  op_q, op_d;
  logic signed [POS_W-1:0]  mx_q, my_q, tx_q, ty_q;
  logic [RAD_W-1:0]         r_q;
  logic [LEN_W-1:0]         spd_q;
  logic [15:0]              ang_q;
  logic signed [TRIG_W-1:0] c_q, s_q;
  logic signed [RND_W-1:0]  offx_q, offy_q, stx_q, sty_q;
  logic [RR_W-1:0]          r2_q;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0]  prod_rnd;
  logic [CLIP_W-1:0]        clip_lim;
  logic                     do_path;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= MUL_CSPD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    busy     = 1'b1;
    q_push_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_d = F_TRIG;
        end
      end
      F_TRIG: begin
        op_d    = MUL_CSPD;
        state_d = F_MUL;
      end
      F_MUL: begin
        unique case (op_q)
          MUL_CSPD: op_d = MUL_SSPD;
          MUL_SSPD: op_d = MUL_CR;
          MUL_CR:   op_d = MUL_SR;
          MUL_SR:   op_d = MUL_RR;
          MUL_RR:   state_d = F_PUSH;
          default:  op_d = MUL_CSPD;
        endcase
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Shared multiplier operand select.
  always_comb begin
    unique case (op_q)
      MUL_CSPD: begin
        mul_a = MULA_W'(c_q);
        mul_b = $signed(MULB_W'(spd_q));
      end
      MUL_SSPD: begin
        mul_a = MULA_W'(s_q);
        mul_b = $signed(MULB_W'(spd_q));
      end
      MUL_CR: begin
        mul_a = MULA_W'(c_q);
        mul_b = $signed(MULB_W'(r_q));
      end
      MUL_SR: begin
        mul_a = MULA_W'(s_q);
        mul_b = $signed(MULB_W'(r_q));
      end
      default: begin
        mul_a = $signed(MULA_W'(r_q));
        mul_b = $signed(MULB_W'(r_q));
      end
    endcase
    prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    prod_rnd = round14(prod);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start) begin
      mx_q  <= mover_x_i;
      my_q  <= mover_y_i;
      tx_q  <= target_x_i;
      ty_q  <= target_y_i;
      r_q   <= RAD_W'(mover_radius_i) + RAD_W'(target_radius_i);
      spd_q <= mover_speed_i;
      ang_q <= 16'(heading_i[ANGLE_BITS-1:0]) << (16 - ANGLE_BITS);
    end
    if (state_q == F_TRIG) begin
      c_q <= sine16(ang_q + 16'h4000);
      s_q <= sine16(ang_q);
    end
    if (state_q == F_MUL) begin
      case (op_q)
        MUL_CSPD: offx_q <= prod_rnd;
        MUL_SSPD: offy_q <= prod_rnd;
        MUL_CR:   stx_q  <= prod_rnd;
        MUL_SR:   sty_q  <= prod_rnd;
        default:  r2_q   <= RR_W'(prod);
      endcase
    end
  end

  // Path sampling runs only when the combined radius is nonzero and the mover outruns it.
  assign do_path  = (r_q != '0) && (RAD_W'(spd_q) > r_q);
  assign clip_lim = CLIP_W'(r_q) * CLIP_W'(MAX_STEPS);

  always_comb begin
    q_job_o.mx      = mx_q;
    q_job_o.my      = my_q;
    q_job_o.tx      = tx_q;
    q_job_o.ty      = ty_q;
    q_job_o.px0     = PATH_W'(mx_q) - PATH_W'(offx_q);
    q_job_o.py0     = PATH_W'(my_q) - PATH_W'(offy_q);
    q_job_o.stx     = PATH_W'(stx_q);
    q_job_o.sty     = PATH_W'(sty_q);
    q_job_o.r       = r_q;
    q_job_o.spd     = spd_q;
    q_job_o.r2      = r2_q;
    q_job_o.do_path = do_path;
    q_job_o.clipped = do_path && (CLIP_W'(spd_q) > clip_lim);
  end

endmodule

FILE: design/sch_back.sv
// Sampling back end: walks the path points of one job, tests each through a
// three-stage distance pipeline and reports hit and clip flags.
// Depends on sch_pkg.
`timescale 1ns / 1ps

module sch_back
  import sch_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  job_t q_job_i,
  output logic q_pop_o,
  output logic done,
  output logic hit_o,
  output logic steps_clipped_o
);

  back_state_e              state_q, state_d;
  job_t                     job_q;
  logic signed [PATH_W-1:0] px_q, py_q;
  logic [ACC_W-1:0]         acc_q, acc_n;
  logic [CNT_W-1:0]         k_q, k_n;
  logic                     iss_v, iss_last;
  logic signed [PATH_W-1:0] iss_x, iss_y;
  logic                     s1_v_q, s1_last_q, s2_v_q, s2_last_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]          dx2_q, dy2_q;
  logic [SQ_W:0]            dist2;
  logic                     near;
  logic                     hit_acc_q;
  logic                     done_q, hit_q, clip_q;

  assign acc_n = acc_q + ACC_W'(job_q.r);
  assign k_n   = k_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    iss_v    = 1'b0;
    iss_last = 1'b0;
    iss_x    = px_q;
    iss_y    = py_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = q_job_i.do_path ? B_RUN : B_LAST;
        end
      end
      B_RUN: begin
        iss_v = 1'b1;
        if (acc_n >= ACC_W'(job_q.spd) || k_n == CNT_W'(MAX_STEPS)) begin
          state_d = B_LAST;
        end
      end
      B_LAST: begin
        iss_v    = 1'b1;
        iss_last = 1'b1;
        iss_x    = PATH_W'(job_q.mx);
        iss_y    = PATH_W'(job_q.my);
        state_d  = B_DRAIN;
      end
      B_DRAIN: begin
        if (s2_v_q && s2_last_q) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s2_v_q    <= 1'b0;
      s2_last_q <= 1'b0;
      hit_acc_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_v_q    <= iss_v;
      s1_last_q <= iss_last;
      s2_v_q    <= s1_v_q;
      s2_last_q <= s1_last_q;
      done_q    <= s2_v_q && s2_last_q;
      if (q_pop_o) begin
        hit_acc_q <= 1'b0;
      end else if (s2_v_q) begin
        hit_acc_q <= hit_acc_q | near;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
      px_q  <= q_job_i.px0;
      py_q  <= q_job_i.py0;
      acc_q <= '0;
      k_q   <= '0;
    end else if (state_q == B_RUN) begin
      px_q  <= px_q + job_q.stx;
      py_q  <= py_q + job_q.sty;
      acc_q <= acc_n;
      k_q   <= k_n;
    end
    dx_q  <= DIFF_W'(iss_x) - DIFF_W'(job_q.tx);
    dy_q  <= DIFF_W'(iss_y) - DIFF_W'(job_q.ty);
    dx2_q <= SQ_W'(SQ_W'(dx_q) * SQ_W'(dx_q));
    dy2_q <= SQ_W'(SQ_W'(dy_q) * SQ_W'(dy_q));
    hit_q  <= hit_acc_q | near;
    clip_q <= job_q.clipped;
  end

  assign dist2 = (SQ_W+1)'(dx2_q) + (SQ_W+1)'(dy2_q);
  assign near  = dist2 < (SQ_W+1)'(job_q.r2);

  assign done            = done_q;
  assign hit_o           = hit_q;
  assign steps_clipped_o = clip_q;

endmodule

FILE: design/swept_circle_hit_test.sv
// Top level of the swept circle hit test: front end, job queue, back end.
// Depends on sch_pkg, sch_front, sch_fifo and sch_back.
`timescale 1ns / 1ps

// Usage:
//   Request channel: drive the eight fields and raise start. A transaction is
//   taken at a rising edge with start high and busy low. busy stays high while
//   the front end sets the job up (trig lookup, multiplies, push), and longer
//   while it waits for room in the two-entry job queue.
//   Result channel: done pulses for one cycle with hit_o and steps_clipped_o.
//   The receiver cannot stall; results leave in request order.
//   Flow: setup in the front end, a pass through the job queue, then one
//   issue per path sample (N = ceil(speed / combined radius), at most
//   MAX_STEPS, zero when speed does not exceed the radius), one for the
//   current position, and the distance pipeline.
//   Overlap: the sample walk issues one point per cycle and the back end
//   takes the next job only after the last one drains; setup of the next
//   request overlaps with it, and the front end takes a request only after
//   it has pushed the previous job.
//   Reset: clears both sequencers and the queue; no transaction is in flight
//   afterward and done stays low until a new request completes.
module swept_circle_hit_test
  import sch_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] mover_x_i,
  input  logic signed [POS_W-1:0] mover_y_i,
  input  logic signed [POS_W-1:0] target_x_i,
  input  logic signed [POS_W-1:0] target_y_i,
  input  logic [LEN_W-1:0]        mover_radius_i,
  input  logic [LEN_W-1:0]        target_radius_i,
  input  logic [LEN_W-1:0]        mover_speed_i,
  input  logic [LEN_W-1:0]        heading_i,
  output logic                    done,
  output logic                    hit_o,
  output logic                    steps_clipped_o
);

  // Job handoff between the two halves.
  logic q_push, q_pop, q_full, q_empty;
  job_t q_wjob, q_rjob;

  // Set up the job: trig lookup, start point, step vector, r squared.
  sch_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mover_x_i       (mover_x_i),
    .mover_y_i       (mover_y_i),
    .target_x_i      (target_x_i),
    .target_y_i      (target_y_i),
    .mover_radius_i  (mover_radius_i),
    .target_radius_i (target_radius_i),
    .mover_speed_i   (mover_speed_i),
    .heading_i       (heading_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_job_o         (q_wjob)
  );

  // Buffer up to two jobs so setup and sampling stall independently.
  sch_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_wjob),
    .pop_i   (q_pop),
    .job_o   (q_rjob),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Walk the samples, test each, and emit one result per job.
  sch_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_job_i         (q_rjob),
    .q_pop_o         (q_pop),
    .done            (done),
    .hit_o           (hit_o),
    .steps_clipped_o (steps_clipped_o)
  );

`ifndef SYNTHESIS
  // Queue cannot report full and empty together.
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("job queue full and empty at once");

  // Front end pushes only into a queue with room.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  // A taken request keeps the front end busy on the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("front end not busy after accepting a request");
`endif

endmodule
